// ===== src/tlc_pkg.sv =====
package tlc_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;
    localparam int DUR_BITS = 16;
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [3:0] {
        PH_MIN_GREEN   = 4'd0,
        PH_WAIT        = 4'd1,
        PH_MAIN_YELLOW = 4'd2,
        PH_MAIN_RED    = 4'd3,
        PH_WALK        = 4'd4,
        PH_WALK_CLEAR  = 4'd5,
        PH_SIDE_GREEN  = 4'd6,
        PH_SIDE_YELLOW = 4'd7,
        PH_SIDE_RED    = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        LIGHT_RED    = 2'd0,
        LIGHT_YELLOW = 2'd1,
        LIGHT_GREEN  = 2'd2
    } light_t;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_GREEN  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_YELLOW     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ALL_RED    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WALK       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WALK_CLEAR = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SIDE_GREEN = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXTEND     = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_EXT    = 3'd7;

    localparam logic [DUR_BITS-1:0] MIN_GREEN_RESET  = 16'd300;
    localparam logic [DUR_BITS-1:0] YELLOW_RESET     = 16'd60;
    localparam logic [DUR_BITS-1:0] ALL_RED_RESET    = 16'd10;
    localparam logic [DUR_BITS-1:0] WALK_RESET       = 16'd200;
    localparam logic [DUR_BITS-1:0] WALK_CLEAR_RESET = 16'd100;
    localparam logic [DUR_BITS-1:0] SIDE_GREEN_RESET = 16'd100;
    localparam logic [DUR_BITS-1:0] EXTEND_RESET     = 16'd100;
    localparam logic [1:0]          MAX_EXT_RESET    = 2'd2;

endpackage

// ===== src/traffic_light_controller.sv =====
// Traffic light controller with pedestrian and side-car requests. Each input transfer is one
// tick carrying the two button states and yields exactly one result transfer with the main and
// side lights, the walk signal and the phase reached after that tick. The phase, tick timer and
// request flags update together from a single registered pass, so a tick can be taken every
// clock unless stalled; the result register frees as it is taken, and in_stall rises only while
// a result waits under out_stall. The timer is TIMER_BITS wide and saturates, ending the phase
// at its maximum. Phase durations and the extension limit are written through the cfg port
// (index 0 to 7 in the order min green, yellow, all red, walk, walk clear, side green, extend,
// max extensions); cfg_ready is always high and writes are meant for when no tick is in flight.
module traffic_light_controller #(
    parameter int TIMER_BITS = tlc_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tlc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tlc_pkg::DUR_BITS-1:0]       cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               ped_button,
    input  logic                               car_button,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         main_lamp,
    output logic [1:0]                         side_lamp,
    output logic                               walk_signal,
    output logic [3:0]                         phase_code
);
    import tlc_pkg::*;

    localparam int CMP_BITS = (TIMER_BITS > DUR_BITS) ? TIMER_BITS : DUR_BITS;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    logic [DUR_BITS-1:0] min_green_reg;
    logic [DUR_BITS-1:0] yellow_reg;
    logic [DUR_BITS-1:0] all_red_reg;
    logic [DUR_BITS-1:0] walk_reg;
    logic [DUR_BITS-1:0] walk_clear_reg;
    logic [DUR_BITS-1:0] side_green_reg;
    logic [DUR_BITS-1:0] extend_reg;
    logic [1:0]          max_ext_reg;

    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic                  request_latched_reg, request_latched_next;
    logic                  walk_requested_reg, walk_requested_next;
    logic                  extend_requested_reg, extend_requested_next;
    logic [1:0]            extensions_used_reg, extensions_used_next;

    logic                  out_valid_reg;
    light_t                main_lamp_reg, main_lamp_next;
    light_t                side_lamp_reg, side_lamp_next;
    logic                  walk_signal_reg, walk_signal_next;

    logic                  accept;
    logic [DUR_BITS-1:0]   dur;
    logic [TIMER_BITS-1:0] timer_inc;
    logic                  done;

    assign cfg_ready   = 1'b1;
    assign in_stall    = out_valid_reg & out_stall;
    assign accept      = in_valid & ~in_stall;
    assign out_valid   = out_valid_reg;
    assign main_lamp   = main_lamp_reg;
    assign side_lamp   = side_lamp_reg;
    assign walk_signal = walk_signal_reg;
    assign phase_code  = phase_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_green_reg  <= MIN_GREEN_RESET;
            yellow_reg     <= YELLOW_RESET;
            all_red_reg    <= ALL_RED_RESET;
            walk_reg       <= WALK_RESET;
            walk_clear_reg <= WALK_CLEAR_RESET;
            side_green_reg <= SIDE_GREEN_RESET;
            extend_reg     <= EXTEND_RESET;
            max_ext_reg    <= MAX_EXT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_GREEN:  min_green_reg  <= cfg_data;
                CFG_YELLOW:     yellow_reg     <= cfg_data;
                CFG_ALL_RED:    all_red_reg    <= cfg_data;
                CFG_WALK:       walk_reg       <= cfg_data;
                CFG_WALK_CLEAR: walk_clear_reg <= cfg_data;
                CFG_SIDE_GREEN: side_green_reg <= cfg_data;
                CFG_EXTEND:     extend_reg     <= cfg_data;
                CFG_MAX_EXT:    max_ext_reg    <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    // duration of the current phase and end-of-phase check
    always_comb
    begin
        case (phase_reg)
            PH_MIN_GREEN:                  dur = min_green_reg;
            PH_MAIN_YELLOW, PH_SIDE_YELLOW: dur = yellow_reg;
            PH_MAIN_RED, PH_SIDE_RED:      dur = all_red_reg;
            PH_WALK:                       dur = walk_reg;
            PH_WALK_CLEAR:                 dur = walk_clear_reg;
            PH_SIDE_GREEN:                 dur = (extensions_used_reg == 2'd0) ?
                                                 side_green_reg : extend_reg;
            default:                       dur = min_green_reg;
        endcase
        timer_inc = (timer_reg == TIMER_MAX) ? timer_reg : timer_reg + 1'b1;
        done = (CMP_BITS'(timer_inc) >= CMP_BITS'(dur)) || (timer_inc == TIMER_MAX);
    end

    // phase sequencing
    always_comb
    begin
        phase_next            = phase_reg;
        timer_next            = timer_reg;
        request_latched_next  = request_latched_reg;
        walk_requested_next   = walk_requested_reg;
        extend_requested_next = extend_requested_reg;
        extensions_used_next  = extensions_used_reg;

        case (phase_reg)
            PH_MIN_GREEN, PH_WAIT:
            begin
                if (!request_latched_reg && (ped_button || car_button))
                begin
                    request_latched_next = 1'b1;
                    walk_requested_next  = ped_button & ~car_button;
                end
                if (phase_reg == PH_MIN_GREEN)
                begin
                    timer_next = done ? '0 : timer_inc;
                    if (done)
                        phase_next = request_latched_next ? PH_MAIN_YELLOW : PH_WAIT;
                end
                else if (request_latched_next)
                begin
                    phase_next = PH_MAIN_YELLOW;
                    timer_next = '0;
                end
            end
            PH_MAIN_YELLOW, PH_WALK, PH_WALK_CLEAR, PH_SIDE_YELLOW:
            begin
                timer_next = done ? '0 : timer_inc;
                if (done)
                begin
                    case (phase_reg)
                        PH_MAIN_YELLOW: phase_next = PH_MAIN_RED;
                        PH_WALK:        phase_next = PH_WALK_CLEAR;
                        PH_SIDE_YELLOW: phase_next = PH_SIDE_RED;
                        default:        phase_next = PH_SIDE_YELLOW;
                    endcase
                end
            end
            PH_MAIN_RED:
            begin
                timer_next = done ? '0 : timer_inc;
                if (done)
                begin
                    phase_next            = walk_requested_reg ? PH_WALK : PH_SIDE_GREEN;
                    extend_requested_next = 1'b0;
                    extensions_used_next  = 2'd0;
                end
            end
            PH_SIDE_GREEN:
            begin
                if (car_button && !ped_button)
                    extend_requested_next = 1'b1;
                timer_next = done ? '0 : timer_inc;
                if (done)
                begin
                    if (extend_requested_next && (extensions_used_reg < max_ext_reg))
                    begin
                        extensions_used_next  = extensions_used_reg + 2'd1;
                        extend_requested_next = 1'b0;
                    end
                    else
                        phase_next = PH_SIDE_YELLOW;
                end
            end
            PH_SIDE_RED:
            begin
                timer_next = done ? '0 : timer_inc;
                if (done)
                begin
                    phase_next            = PH_MIN_GREEN;
                    request_latched_next  = 1'b0;
                    walk_requested_next   = 1'b0;
                    extend_requested_next = 1'b0;
                    extensions_used_next  = 2'd0;
                end
            end
            default:
            begin
                phase_next = PH_MIN_GREEN;
                timer_next = '0;
            end
        endcase
    end

    // light decode of the phase after this tick
    always_comb
    begin
        main_lamp_next   = LIGHT_RED;
        side_lamp_next   = LIGHT_RED;
        walk_signal_next = 1'b0;
        case (phase_next)
            PH_MIN_GREEN, PH_WAIT:       main_lamp_next = LIGHT_GREEN;
            PH_MAIN_YELLOW:              main_lamp_next = LIGHT_YELLOW;
            PH_WALK:
            begin
                side_lamp_next   = LIGHT_GREEN;
                walk_signal_next = 1'b1;
            end
            PH_WALK_CLEAR, PH_SIDE_GREEN: side_lamp_next = LIGHT_GREEN;
            PH_SIDE_YELLOW:              side_lamp_next = LIGHT_YELLOW;
            default:                     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_MIN_GREEN;
            timer_reg            <= '0;
            request_latched_reg  <= 1'b0;
            walk_requested_reg   <= 1'b0;
            extend_requested_reg <= 1'b0;
            extensions_used_reg  <= 2'd0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg            <= phase_next;
                timer_reg            <= timer_next;
                request_latched_reg  <= request_latched_next;
                walk_requested_reg   <= walk_requested_next;
                extend_requested_reg <= extend_requested_next;
                extensions_used_reg  <= extensions_used_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            main_lamp_reg   <= main_lamp_next;
            side_lamp_reg   <= side_lamp_next;
            walk_signal_reg <= walk_signal_next;
        end
    end

`ifndef NO_ASSERTIONS
    // every accepted tick leaves a result ready
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("result missing after accepted tick");

    // conflicting greens never shown
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (main_lamp_reg == LIGHT_RED) || (side_lamp_reg == LIGHT_RED))
        else $error("main and side both open");

    // walk only with side green
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && walk_signal_reg) |-> (side_lamp_reg == LIGHT_GREEN))
        else $error("walk without side green");

    // timer restarts on every phase change
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != $past(phase_reg)) |-> (timer_reg == '0))
        else $error("timer not cleared on phase change");

    // end of cycle clears requests
    assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_MIN_GREEN) && ($past(phase_reg) == PH_SIDE_RED))
        |-> (!request_latched_reg && (extensions_used_reg == 2'd0)))
        else $error("requests not cleared at end of cycle");
`endif

endmodule

// ===== tb/tb_traffic_light_controller.sv =====
module tb_traffic_light_controller;

    import tlc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        light_t main_l;
        light_t side_l;
        logic   walk;
        phase_t ph;
    } lights_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [DUR_BITS-1:0]       cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic                      ped_button;
    logic                      car_button;
    logic                      out_valid;
    logic                      out_stall;
    logic [1:0]                main_lamp;
    logic [1:0]                side_lamp;
    logic                      walk_signal;
    logic [3:0]                phase_code;

    // predicted controller state
    phase_t        ph;
    logic [15:0]   tmr;
    logic          req_lat;
    logic          walk_req;
    logic          ext_req;
    logic [1:0]    ext_used;
    logic [15:0]   cfg_regs [0:7];

    lights_t       expected_lights [$];
    lights_t       want;
    int            mismatches;
    int            ticks_sent;
    int            reg_writes;
    int            idle_pct;
    int            cycle_count;

    traffic_light_controller u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .ped_button  (ped_button),
        .car_button  (car_button),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .main_lamp   (main_lamp),
        .side_lamp   (side_lamp),
        .walk_signal (walk_signal),
        .phase_code  (phase_code)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function void reset_predictor();
        ph = PH_MIN_GREEN;
        tmr = '0;
        req_lat = 1'b0;
        walk_req = 1'b0;
        ext_req = 1'b0;
        ext_used = 2'd0;
        cfg_regs[CFG_MIN_GREEN] = MIN_GREEN_RESET;
        cfg_regs[CFG_YELLOW] = YELLOW_RESET;
        cfg_regs[CFG_ALL_RED] = ALL_RED_RESET;
        cfg_regs[CFG_WALK] = WALK_RESET;
        cfg_regs[CFG_WALK_CLEAR] = WALK_CLEAR_RESET;
        cfg_regs[CFG_SIDE_GREEN] = SIDE_GREEN_RESET;
        cfg_regs[CFG_EXTEND] = EXTEND_RESET;
        cfg_regs[CFG_MAX_EXT] = {14'd0, MAX_EXT_RESET};
    endfunction

    // counts one tick, true when a phase of length dur is over
    function bit count_tick(input logic [15:0] dur);
        if (tmr != 16'hffff)
            tmr = tmr + 16'd1;
        if (tmr >= dur || tmr == 16'hffff)
        begin
            tmr = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void enter(input phase_t next);
        ph = next;
        tmr = '0;
    endfunction

    function void latch_press(input logic ped, input logic car);
        if (!req_lat && (ped || car))
        begin
            req_lat = 1'b1;
            walk_req = ped && !car;
        end
    endfunction

    function lights_t advance_tick(input logic ped, input logic car);
        lights_t r;
        case (ph)
            PH_MIN_GREEN:
            begin
                latch_press(ped, car);
                if (count_tick(cfg_regs[CFG_MIN_GREEN]))
                    enter(req_lat ? PH_MAIN_YELLOW : PH_WAIT);
            end
            PH_WAIT:
            begin
                latch_press(ped, car);
                if (req_lat)
                    enter(PH_MAIN_YELLOW);
            end
            PH_MAIN_YELLOW:
            begin
                if (count_tick(cfg_regs[CFG_YELLOW]))
                    enter(PH_MAIN_RED);
            end
            PH_MAIN_RED:
            begin
                if (count_tick(cfg_regs[CFG_ALL_RED]))
                begin
                    enter(walk_req ? PH_WALK : PH_SIDE_GREEN);
                    ext_req = 1'b0;
                    ext_used = 2'd0;
                end
            end
            PH_WALK:
            begin
                if (count_tick(cfg_regs[CFG_WALK]))
                    enter(PH_WALK_CLEAR);
            end
            PH_WALK_CLEAR:
            begin
                if (count_tick(cfg_regs[CFG_WALK_CLEAR]))
                    enter(PH_SIDE_YELLOW);
            end
            PH_SIDE_GREEN:
            begin
                if (car && !ped)
                    ext_req = 1'b1;
                if (count_tick(ext_used == 2'd0 ? cfg_regs[CFG_SIDE_GREEN]
                                                : cfg_regs[CFG_EXTEND]))
                begin
                    if (ext_req && ext_used < cfg_regs[CFG_MAX_EXT][1:0])
                    begin
                        ext_used = ext_used + 2'd1;
                        ext_req = 1'b0;
                    end
                    else
                        enter(PH_SIDE_YELLOW);
                end
            end
            PH_SIDE_YELLOW:
            begin
                if (count_tick(cfg_regs[CFG_YELLOW]))
                    enter(PH_SIDE_RED);
            end
            PH_SIDE_RED:
            begin
                if (count_tick(cfg_regs[CFG_ALL_RED]))
                begin
                    enter(PH_MIN_GREEN);
                    req_lat = 1'b0;
                    walk_req = 1'b0;
                    ext_req = 1'b0;
                    ext_used = 2'd0;
                end
            end
            default:
                enter(PH_MIN_GREEN);
        endcase

        r.main_l = LIGHT_RED;
        r.side_l = LIGHT_RED;
        r.walk = 1'b0;
        r.ph = ph;
        case (ph)
            PH_MIN_GREEN, PH_WAIT:
                r.main_l = LIGHT_GREEN;
            PH_MAIN_YELLOW:
                r.main_l = LIGHT_YELLOW;
            PH_WALK:
            begin
                r.side_l = LIGHT_GREEN;
                r.walk = 1'b1;
            end
            PH_WALK_CLEAR, PH_SIDE_GREEN:
                r.side_l = LIGHT_GREEN;
            PH_SIDE_YELLOW:
                r.side_l = LIGHT_YELLOW;
            default:
                ;
        endcase
        return r;
    endfunction

    // {ped, car}, biased toward presses that move the controller on
    function logic [1:0] pick_buttons();
        logic [1:0] b;
        b = 2'b00;
        case (ph)
            PH_MIN_GREEN, PH_WAIT:
                if ($urandom_range(0, 3) == 0)
                    b = 2'($urandom_range(1, 3));
            PH_SIDE_GREEN:
                b = 2'($urandom_range(0, 3));
            default:
                if ($urandom_range(0, 7) == 0)
                    b = 2'($urandom_range(1, 3));
        endcase
        return b;
    endfunction

    task send_tick(input logic ped, input logic car);
        in_valid <= 1'b1;
        ped_button <= ped;
        car_button <= car;
        do
            @(posedge clk);
        while (in_stall);
        expected_lights.push_back(advance_tick(ped, car));
        ticks_sent++;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task send_random_tick();
        logic [1:0] b;
        b = pick_buttons();
        send_tick(b[1], b[0]);
    endtask

    task drain_results();
        in_valid <= 1'b0;
        while (expected_lights.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_regs[idx] = (idx == CFG_MAX_EXT) ? (data & 16'h0003) : data;
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task apply_timing(input logic [15:0] mg, input logic [15:0] yl, input logic [15:0] ar,
                      input logic [15:0] wk, input logic [15:0] wc, input logic [15:0] sg,
                      input logic [15:0] ex, input logic [15:0] mx);
        drain_results();
        write_reg(CFG_MIN_GREEN, mg);
        write_reg(CFG_YELLOW, yl);
        write_reg(CFG_ALL_RED, ar);
        write_reg(CFG_WALK, wk);
        write_reg(CFG_WALK_CLEAR, wc);
        write_reg(CFG_SIDE_GREEN, sg);
        write_reg(CFG_EXTEND, ex);
        write_reg(CFG_MAX_EXT, mx);
    endtask

    function logic [15:0] random_duration();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd1;
            8: return 16'($urandom_range(7, 30));
            9: return 16'($urandom_range(31, 60));
            default: return 16'($urandom_range(2, 6));
        endcase
    endfunction

    task test_reset_timing();
        int n;
        n = 0;
        while (ph == PH_MIN_GREEN || n < 5)
        begin
            send_tick(n == 20, 1'b0);
            n++;
        end
        while (ph != PH_MIN_GREEN)
            send_random_tick();
    endtask

    task test_walk_request();
        while (ph != PH_WAIT)
            send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        while (ph != PH_MIN_GREEN)
            send_tick(1'b1, 1'b1);
    endtask

    task test_car_extensions();
        send_tick(1'b1, 1'b1);
        while (ph != PH_SIDE_GREEN)
            send_tick(1'b0, 1'b0);
        while (ph == PH_SIDE_GREEN)
            send_tick(1'b0, 1'b1);
        while (ph != PH_MIN_GREEN)
            send_tick(1'b0, 1'b0);
    endtask

    task test_both_in_side_green();
        send_tick(1'b0, 1'b1);
        while (ph != PH_SIDE_GREEN)
            send_tick(1'b1, 1'b0);
        while (ph == PH_SIDE_GREEN)
            send_tick(1'b1, 1'b1);
        while (ph != PH_MIN_GREEN)
            send_tick(1'b1, 1'b0);
    endtask

    task test_random_timing();
        int s;
        int k;
        logic [15:0] mx;
        for (s = 0; s < 5; s++)
        begin
            mx = (16'($urandom) & 16'hfffc) | 16'(s % 4);
            apply_timing(random_duration(), random_duration(), random_duration(),
                         random_duration(), random_duration(), random_duration(),
                         random_duration(), mx);
            idle_pct = (s == 3) ? 0 : $urandom_range(5, 40);
            for (k = 0; k < 140; k++)
            begin
                if (k == 70 && s == 2)
                    drain_results();
                send_random_tick();
            end
        end
    endtask

    // min green of one, other durations at the top of their range
    task test_long_durations();
        apply_timing(16'd1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                     16'hffff);
        repeat (20)
            send_random_tick();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_lights.size() == 0)
            begin
                $error("result transfer with nothing expected");
                mismatches++;
            end
            else
            begin
                want = expected_lights.pop_front();
                if (main_lamp !== want.main_l)
                begin
                    $error("main_lamp expected %0d actual %0d", want.main_l, main_lamp);
                    mismatches++;
                end
                if (side_lamp !== want.side_l)
                begin
                    $error("side_lamp expected %0d actual %0d", want.side_l, side_lamp);
                    mismatches++;
                end
                if (walk_signal !== want.walk)
                begin
                    $error("walk_signal expected %0d actual %0d", want.walk, walk_signal);
                    mismatches++;
                end
                if (phase_code !== want.ph)
                begin
                    $error("phase_code expected %0d actual %0d", want.ph, phase_code);
                    mismatches++;
                end
            end
        end
    end

    always
    begin
        @(posedge clk);
        if (rst_n && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cycle_count = 0;
        mismatches = 0;
        ticks_sent = 0;
        reg_writes = 0;
        idle_pct = 0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        ped_button <= 1'b0;
        car_button <= 1'b0;
        out_stall <= 1'b0;
        reset_predictor();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 10;
        test_reset_timing();
        // zero durations act as one tick
        apply_timing(16'd2, 16'd0, 16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd3);
        idle_pct = 25;
        test_walk_request();
        test_car_extensions();
        test_both_in_side_green();
        test_random_timing();
        idle_pct = 0;
        test_long_durations();
        drain_results();
        repeat (5) @(posedge clk);

        $display("%0d ticks checked across %0d register writes", ticks_sent, reg_writes);
        $display("walk and car cycles, extensions, random timings and long durations");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== traffic_light_controller.f =====
src/tlc_pkg.sv
src/traffic_light_controller.sv
tb/tb_traffic_light_controller.sv
